// ===== rtl/cspm_pkg.sv =====
// ----------------------------------------------------------------------------
// cspm_pkg
// Shared types and constants for the constant string pattern matcher.
// ----------------------------------------------------------------------------
package cspm_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int LEN_W             = $clog2(MAX_PATTERN_BYTES + 2);
  localparam int IDX_W             = $clog2(MAX_PATTERN_BYTES);
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_IDX_W         = 2;

  typedef enum logic [1:0] {
    MODE_EQUALS   = 2'd0,
    MODE_STARTS   = 2'd1,
    MODE_ENDS     = 2'd2,
    MODE_CONTAINS = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH_MODE     = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1,
    CFG_PATTERN_LOW    = 2'd2,
    CFG_PATTERN_HIGH   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_present;
    logic       last_byte;
    logic       value_null;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    mode_t                              mode;
    logic [LEN_W-1:0]                   len;
    logic [MAX_PATTERN_BYTES-1:0][7:0]  pattern;
  } cfg_t;

endpackage

// ===== rtl/cspm_if.sv =====
// ----------------------------------------------------------------------------
// cspm channel interfaces
// Valid/ready channels for input bytes and match results.
// ----------------------------------------------------------------------------
interface cspm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       byte_present;
  logic       last_byte;
  logic       value_null;

  modport source (output valid, value_byte, byte_present, last_byte, value_null,
                  input ready);
  modport sink   (input valid, value_byte, byte_present, last_byte, value_null,
                  output ready);
endinterface

interface cspm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic result_null;

  modport source (output valid, matched, result_null, input ready);
  modport sink   (input valid, matched, result_null, output ready);
endinterface

// ===== rtl/cspm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cspm_cfg_regs
// Configuration register file: mode, pattern length and pattern bytes.
// ----------------------------------------------------------------------------
module cspm_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cspm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cspm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output cspm_pkg::cfg_t                  cfg
);

  cspm_pkg::mode_t               mode_r;
  logic [cspm_pkg::LEN_W-1:0]    len_r;
  logic [cspm_pkg::CFG_DATA_W-1:0] pat_low_r;
  logic [cspm_pkg::CFG_DATA_W-1:0] pat_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= cspm_pkg::MODE_CONTAINS;
      len_r      <= '0;
      pat_low_r  <= '0;
      pat_high_r <= '0;
    end else if (cfg_we) begin
      case (cspm_pkg::cfg_reg_t'(cfg_index))
        cspm_pkg::CFG_MATCH_MODE:     mode_r     <= cspm_pkg::mode_t'(cfg_wdata[1:0]);
        cspm_pkg::CFG_PATTERN_LENGTH: len_r      <= cfg_wdata[cspm_pkg::LEN_W-1:0];
        cspm_pkg::CFG_PATTERN_LOW:    pat_low_r  <= cfg_wdata;
        cspm_pkg::CFG_PATTERN_HIGH:   pat_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.mode    = mode_r;
    cfg.len     = (len_r > cspm_pkg::LEN_W'(cspm_pkg::MAX_PATTERN_BYTES))
                  ? cspm_pkg::LEN_W'(cspm_pkg::MAX_PATTERN_BYTES) : len_r;
    cfg.pattern = {pat_high_r, pat_low_r};
  end

endmodule

// ===== rtl/cspm_in_stage.sv =====
// ----------------------------------------------------------------------------
// cspm_in_stage
// Input register: captures one input transaction per cycle when not stalled.
// ----------------------------------------------------------------------------
module cspm_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  cspm_in_if.sink          in_ch,
  input  logic             take,
  output cspm_pkg::stage_t stage
);

  logic               valid_r;
  cspm_pkg::item_t    item_r;
  logic               load;

  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.value_byte   <= in_ch.value_byte;
      item_r.byte_present <= in_ch.byte_present;
      item_r.last_byte    <= in_ch.last_byte;
      item_r.value_null   <= in_ch.value_null;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

// ===== rtl/cspm_core.sv =====
// ----------------------------------------------------------------------------
// cspm_core
// Per-value match state, byte window compare and result register.
// ----------------------------------------------------------------------------
module cspm_core (
  input  logic             clk,
  input  logic             rst_n,
  input  cspm_pkg::stage_t stage,
  input  cspm_pkg::cfg_t   cfg,
  output logic             take,
  cspm_out_if.source       out_ch
);

  localparam int N = cspm_pkg::MAX_PATTERN_BYTES;
  localparam int L = cspm_pkg::LEN_W;
  localparam int I = cspm_pkg::IDX_W;

  logic [N-1:0][7:0] win_r,  win_nxt;
  logic [L-1:0]      seen_r, seen_nxt;
  logic              prefix_ok_r, prefix_ok_nxt;
  logic              found_r, found_nxt;
  logic              null_r, null_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              matched_r, matched_nxt;
  logic              rnull_r, rnull_nxt;

  logic              tail_hit;
  logic              m;
  logic [L-1:0]      pidx;
  logic              last;

  assign take = stage.valid && (!out_valid_r || out_ch.ready);
  assign last = stage.item.last_byte;

  always_comb begin
    win_nxt       = win_r;
    seen_nxt      = seen_r;
    prefix_ok_nxt = prefix_ok_r;
    null_nxt      = null_r | stage.item.value_null;

    if (stage.item.byte_present) begin
      if (seen_r < cfg.len && stage.item.value_byte != cfg.pattern[seen_r[I-1:0]]) begin
        prefix_ok_nxt = 1'b0;
      end
      win_nxt = {win_r[N-2:0], stage.item.value_byte};
      if (seen_r < L'(N + 1)) begin
        seen_nxt = seen_r + L'(1);
      end
    end

    tail_hit = 1'b1;
    pidx     = '0;
    for (int k = 0; k < N; k++) begin
      if (L'(k) < cfg.len) begin
        pidx = cfg.len - L'(1) - L'(k);
        if (win_nxt[k] != cfg.pattern[pidx[I-1:0]]) begin
          tail_hit = 1'b0;
        end
      end
    end

    found_nxt = found_r | (stage.item.byte_present && cfg.len != '0 &&
                           seen_nxt >= cfg.len && tail_hit);

    case (cfg.mode)
      cspm_pkg::MODE_EQUALS: m = (seen_nxt == cfg.len) && prefix_ok_nxt;
      cspm_pkg::MODE_STARTS: m = (seen_nxt >= cfg.len) && prefix_ok_nxt;
      cspm_pkg::MODE_ENDS:   m = (seen_nxt >= cfg.len) && tail_hit;
      default:               m = (cfg.len == '0) || found_nxt;
    endcase

    out_valid_nxt = out_valid_r && !out_ch.ready;
    matched_nxt   = matched_r;
    rnull_nxt     = rnull_r;
    if (take && last) begin
      out_valid_nxt = 1'b1;
      matched_nxt   = m && !null_nxt;
      rnull_nxt     = null_nxt;
      seen_nxt      = '0;
      prefix_ok_nxt = 1'b1;
      found_nxt     = 1'b0;
      null_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      prefix_ok_r <= 1'b1;
      found_r     <= 1'b0;
      null_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        seen_r      <= seen_nxt;
        prefix_ok_r <= prefix_ok_nxt;
        found_r     <= found_nxt;
        null_r      <= null_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      win_r <= win_nxt;
    end
    matched_r <= matched_nxt;
    rnull_r   <= rnull_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.matched     = matched_r;
  assign out_ch.result_null = rnull_r;

endmodule

// ===== rtl/constant_string_pattern_match.sv =====
// Path: the last byte of a value passes through the input register, and its result is then held in the result register.
// Throughput: one input transaction per cycle; the input register and the result
// register stall together only when a result waits and the output is not ready.
// Reset: synchronous, active-low rst_n; mode resets to contains, pattern to empty,
// per-value state cleared. The byte window is not reset.
// ----------------------------------------------------------------------------
// constant_string_pattern_match
// Streams string bytes and tests each value against a constant pattern in
// equals, starts-with, ends-with or contains mode.
// ----------------------------------------------------------------------------
module constant_string_pattern_match (
  input  logic                            clk,
  input  logic                            rst_n,
  cspm_in_if.sink                         in_ch,
  cspm_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [cspm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cspm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  cspm_pkg::cfg_t   cfg;
  cspm_pkg::stage_t stage;
  logic             take;

  cspm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cspm_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .stage (stage)
  );

  cspm_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .stage  (stage),
    .cfg    (cfg),
    .take   (take),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/cspm_checker.sv =====
// ----------------------------------------------------------------------------
// cspm_checker
// Port-level assertions for the pattern matcher, bound to the top level.
// ----------------------------------------------------------------------------
module cspm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_matched,
  input logic out_result_null
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_matched) &&
                                $stable(out_result_null))
    else $error("result changed while stalled");

  a_null_not_matched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_null |-> !out_matched)
    else $error("null result reported as matched");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_in_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind constant_string_pattern_match cspm_checker u_cspm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_matched     (out_ch.matched),
  .out_result_null (out_ch.result_null)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for constant_string_pattern_match. String values
// are streamed byte by byte under all four match modes and a range of
// pattern settings. A local model of the matcher predicts one result per
// value, and every returned result is checked against it in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_PERIOD   = 4;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1350;
  localparam int SEGMENTS     = 20;
  localparam int SETTLE_CYCLES = 4;
  localparam int VALUE_MAX    = 48;
  localparam logic [63:0] PATTERN_ABC = 64'h0000_0000_0063_6261;

  typedef struct packed {
    logic matched;
    logic result_null;
  } result_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [cspm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cspm_pkg::CFG_DATA_W-1:0] cfg_wdata;

  cspm_in_if  in_ch();
  cspm_out_if out_ch();

  constant_string_pattern_match i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // matcher model state
  cspm_pkg::mode_t                             match_mode_q;
  logic [4:0]                                  pattern_len_q;
  logic [cspm_pkg::MAX_PATTERN_BYTES-1:0][7:0] pattern_q;
  logic [7:0]                                  window_q [cspm_pkg::MAX_PATTERN_BYTES];
  int                                          bytes_seen_q;
  bit                                          prefix_ok_q;
  bit                                          found_q;
  bit                                          null_q;

  result_t expected_results[$];

  int mismatch_count;
  int items_sent;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int hold_left;

  logic [7:0] value_buf [VALUE_MAX];
  int         value_len;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model
  function automatic int used_len();
    return (pattern_len_q > cspm_pkg::MAX_PATTERN_BYTES) ? cspm_pkg::MAX_PATTERN_BYTES
                                                         : int'(pattern_len_q);
  endfunction

  function automatic bit window_ends_with_pattern(int len);
    int k;
    for (k = 0; k < len; k++) begin
      if (window_q[k] !== pattern_q[len - 1 - k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_value_state();
    bytes_seen_q = 0;
    prefix_ok_q  = 1'b1;
    found_q      = 1'b0;
    null_q       = 1'b0;
  endfunction

  function automatic void predict_match(logic [7:0] b, logic present, logic last, logic nul);
    int      len;
    int      k;
    bit      m;
    result_t r;
    len = used_len();
    if (nul) null_q = 1'b1;
    if (present) begin
      if (bytes_seen_q < len && b != pattern_q[bytes_seen_q]) prefix_ok_q = 1'b0;
      for (k = cspm_pkg::MAX_PATTERN_BYTES - 1; k > 0; k--) window_q[k] = window_q[k - 1];
      window_q[0] = b;
      if (bytes_seen_q < cspm_pkg::MAX_PATTERN_BYTES + 1) bytes_seen_q++;
      if (len > 0 && bytes_seen_q >= len && window_ends_with_pattern(len)) found_q = 1'b1;
    end
    if (last) begin
      case (match_mode_q)
        cspm_pkg::MODE_EQUALS: m = (bytes_seen_q == len) && prefix_ok_q;
        cspm_pkg::MODE_STARTS: m = (bytes_seen_q >= len) && prefix_ok_q;
        cspm_pkg::MODE_ENDS:   m = (bytes_seen_q >= len) && window_ends_with_pattern(len);
        default:               m = (len == 0) || found_q;
      endcase
      r.matched     = null_q ? 1'b0 : m;
      r.result_null = null_q;
      expected_results.push_back(r);
      clear_value_state();
    end
  endfunction

  // -------------------------------------------------------------- checking
  task automatic report_mismatch(string msg);
    mismatch_count++;
    // keep the log bounded on a badly broken run
    if (mismatch_count <= 100) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : check_results
    result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transaction with no expected result pending");
      end else begin
        exp_r = expected_results.pop_front();
        if (out_ch.matched !== exp_r.matched)
          report_mismatch($sformatf("matched got %b expected %b",
                                    out_ch.matched, exp_r.matched));
        if (out_ch.result_null !== exp_r.result_null)
          report_mismatch($sformatf("result_null got %b expected %b",
                                    out_ch.result_null, exp_r.result_null));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // -------------------------------------------------------------- driving
  task automatic send_item(logic [7:0] b, logic present, logic last, logic nul);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.value_byte   = b;
    in_ch.byte_present = present;
    in_ch.last_byte    = last;
    in_ch.value_null   = nul;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_match(b, present, last, nul);
    items_sent++;
  endtask

  task automatic send_str(string s, bit nul, bit blank_end);
    int i;
    for (i = 0; i < s.len(); i++)
      send_item(s[i], 1'b1, (i == s.len() - 1) && !blank_end, nul && i == 0);
    if (blank_end || s.len() == 0) send_item(8'hFF, 1'b0, 1'b1, nul && s.len() == 0);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cspm_pkg::cfg_reg_t idx, logic [63:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      cspm_pkg::CFG_MATCH_MODE:     match_mode_q = cspm_pkg::mode_t'(data[1:0]);
      cspm_pkg::CFG_PATTERN_LENGTH: pattern_len_q = data[4:0];
      cspm_pkg::CFG_PATTERN_LOW:    pattern_q[7:0] = data;
      cspm_pkg::CFG_PATTERN_HIGH:   pattern_q[15:8] = data;
      default: ;
    endcase
  endtask

  task automatic apply_config(cspm_pkg::mode_t m, logic [4:0] len, logic [63:0] lo,
                              logic [63:0] hi);
    logic [63:0] d;
    drain_results();
    d      = {$urandom, $urandom};
    d[1:0] = m;
    write_reg(cspm_pkg::CFG_MATCH_MODE, d);
    d      = {$urandom, $urandom};
    d[4:0] = len;
    write_reg(cspm_pkg::CFG_PATTERN_LENGTH, d);
    write_reg(cspm_pkg::CFG_PATTERN_LOW, lo);
    write_reg(cspm_pkg::CFG_PATTERN_HIGH, hi);
  endtask

  // ------------------------------------------------------------ value build
  function automatic logic [63:0] random_pattern_word(int style);
    logic [63:0] w;
    int          k;
    case (style)
      0: w = '0;
      1: w = '1;
      2: for (k = 0; k < 8; k++) w[8*k +: 8] = $urandom_range(1) ? 8'h61 : 8'h62;
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] random_byte();
    logic [7:0] b;
    if ($urandom_range(2) == 0) b = 8'($urandom_range(255));
    else b = pattern_q[$urandom_range(cspm_pkg::MAX_PATTERN_BYTES - 1)];
    return b;
  endfunction

  function automatic void add_byte(logic [7:0] b);
    if (value_len < VALUE_MAX) begin
      value_buf[value_len] = b;
      value_len++;
    end
  endfunction

  function automatic void add_pattern(int len);
    int k;
    for (k = 0; k < len; k++) add_byte(pattern_q[k]);
  endfunction

  function automatic void add_random(int n);
    int k;
    for (k = 0; k < n; k++) add_byte(random_byte());
  endfunction

  task automatic send_random_value();
    int   len;
    int   start;
    int   i;
    bit   nul;
    bit   blank_end;
    logic lst;
    len       = used_len();
    value_len = 0;
    case ($urandom_range(9))
      0: ;
      1: add_random($urandom_range(1, 20));
      2: add_pattern(len);
      3: begin
        add_pattern(len);
        add_random($urandom_range(1, 4));
      end
      4: begin
        add_random($urandom_range(1, 4));
        add_pattern(len);
      end
      5, 6: begin
        add_random($urandom_range(0, 6));
        add_pattern(len);
        add_random($urandom_range(0, 6));
      end
      7: begin
        // near miss: one bit off inside the pattern
        add_random($urandom_range(0, 3));
        start = value_len;
        add_pattern(len);
        if (len > 0) begin
          i = start + $urandom_range(len - 1);
          value_buf[i] = value_buf[i] ^ (8'd1 << $urandom_range(7));
        end
        add_random($urandom_range(0, 3));
      end
      8: begin
        add_pattern($urandom_range(0, len));
        add_pattern(len);
      end
      default: add_random($urandom_range(21, 40));
    endcase
    nul       = ($urandom_range(99) < 8);
    blank_end = (value_len == 0) || ($urandom_range(5) == 0);
    for (i = 0; i < value_len; i++) begin
      if ($urandom_range(9) == 0)
        send_item(8'($urandom_range(255)), 1'b0, 1'b0, nul && $urandom_range(2) == 0);
      lst = (i == value_len - 1) && !blank_end;
      send_item(value_buf[i], 1'b1, lst, nul && ($urandom_range(2) == 0 || lst));
    end
    if (blank_end) send_item(8'($urandom_range(255)), 1'b0, 1'b1, nul);
  endtask

  task automatic random_config(int seg_id);
    int          len;
    int          style;
    logic [63:0] lo;
    logic [63:0] hi;
    case (seg_id % 5)
      0: len = 0;
      1: len = 1;
      2: len = cspm_pkg::MAX_PATTERN_BYTES;
      3: len = (seg_id == 3) ? 31 : $urandom_range(17, 31);
      default: len = $urandom_range(2, 15);
    endcase
    style = $urandom_range(5);
    lo    = random_pattern_word(style);
    hi    = random_pattern_word(style);
    apply_config(cspm_pkg::mode_t'(seg_id[1:0]), len[4:0], lo, hi);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // reset settings: contains with an empty pattern
    send_str("", 1'b0, 1'b0);
    apply_config(cspm_pkg::MODE_EQUALS, 5'd3, PATTERN_ABC, '1);
    send_str("abc", 1'b0, 1'b0);
    send_str("ab", 1'b0, 1'b1);
    apply_config(cspm_pkg::MODE_STARTS, 5'd3, PATTERN_ABC, '1);
    send_str("abcz", 1'b0, 1'b0);
    apply_config(cspm_pkg::MODE_ENDS, 5'd3, PATTERN_ABC, '1);
    send_str("zabc", 1'b0, 1'b1);
    apply_config(cspm_pkg::MODE_CONTAINS, 5'd3, PATTERN_ABC, '1);
    send_str("xabcy", 1'b0, 1'b0);
    send_str("ab", 1'b1, 1'b0);
    // oversized length clamps to the full pattern
    apply_config(cspm_pkg::MODE_EQUALS, 5'd31, PATTERN_ABC, '1);
    send_str("", 1'b0, 1'b0);
    apply_config(cspm_pkg::MODE_EQUALS, 5'd0, PATTERN_ABC, '1);
    send_str("", 1'b0, 1'b0);
    send_str("q", 1'b0, 1'b0);
  endtask

  task automatic test_random_traffic();
    int seg_id;
    int target;
    for (seg_id = 0; seg_id < SEGMENTS; seg_id++) begin
      case (seg_id / 5)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 70;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 70;
        end
        default: begin
          send_idle_pct  = 38;
          recv_stall_pct = 38;
        end
      endcase
      random_config(seg_id);
      target = items_sent + RANDOM_ITEMS / SEGMENTS;
      while (items_sent < target) send_random_value();
    end
  endtask

  task automatic test_backpressure();
    int target;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_config($urandom_range(SEGMENTS - 1));
    hold_request = 300;
    target       = items_sent + 120;
    while (items_sent < target) send_random_value();
    drain_results();
    target = items_sent + 40;
    while (items_sent < target) send_random_value();
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = cspm_pkg::CFG_MATCH_MODE;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.value_byte   = '0;
    in_ch.byte_present = 1'b0;
    in_ch.last_byte    = 1'b0;
    in_ch.value_null   = 1'b0;
    out_ch.ready       = 1'b0;
    mismatch_count     = 0;
    items_sent         = 0;
    cycle_count        = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_request       = 0;
    hold_left          = 0;
    match_mode_q       = cspm_pkg::MODE_CONTAINS;
    pattern_len_q      = '0;
    pattern_q          = '0;
    foreach (window_q[k]) window_q[k] = '0;
    clear_value_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_random_traffic();
    test_backpressure();
    drain_results();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cspm_pkg.sv
rtl/cspm_if.sv
rtl/cspm_cfg_regs.sv
rtl/cspm_in_stage.sv
rtl/cspm_core.sv
rtl/constant_string_pattern_match.sv
rtl/cspm_checker.sv
tb/tb.sv
